@@ rtl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// Arena and granule sizes are assumed to be powers of two.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int DEF_ARENA_BYTES   = 1024;
   localparam int DEF_GRANULE_BYTES = 16;

   localparam int REQ_W    = 10;
   localparam int OFF_W    = 10;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

   typedef struct packed {
      logic             mode;
      logic [REQ_W-1:0] request_bytes;
      logic [OFF_W-1:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFF_W-1:0]    payload_offset;
   } result_type;

endpackage

@@ rtl/ffba_ram.sv @@
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/ffba_engine.sv @@
// ----------------------------------------------------------------------------
// ffba_engine
// Block list walker: start and in-use maps in flops, block sizes in a RAM
// indexed by header granule. Walks one block per cycle, splits a hit block when the remainder fits.
// ----------------------------------------------------------------------------
module ffba_engine
   import ffba_pkg::*;
#(
   parameter int ARENA_BYTES   = DEF_ARENA_BYTES,
   parameter int GRANULE_BYTES = DEF_GRANULE_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req,
   output logic       res_valid,
   input  logic       res_ready,
   output result_type res
);

   localparam int NUM_G = ARENA_BYTES / GRANULE_BYTES;
   localparam int GW    = $clog2(NUM_G);
   localparam int GS    = $clog2(GRANULE_BYTES);
   localparam int IW    = (GW > OFF_W) ? GW : OFF_W;
   localparam int CW    = IW + 3;

   typedef enum logic [1:0] {IDLE, WALK, SPLIT, RESULT} state_type;

   state_type        state_ff, state_in;
   logic [NUM_G-1:0] start_ff, start_in;
   logic [NUM_G-1:0] used_ff, used_in;
   logic             init_ff, init_in;
   logic [GW:0]      g_ff, g_in;
   logic [CW-1:0]    need_ff, need_in;
   logic [GW-1:0]    ng_ff, ng_in;
   logic [GW-1:0]    rem_ff, rem_in;
   result_type       res_ff, res_in;

   logic             mem_we;
   logic [GW-1:0]    mem_waddr;
   logic [GW-1:0]    mem_wdata;
   logic [GW-1:0]    mem_raddr;
   logic [GW-1:0]    mem_rdata;

   logic [GW-1:0]    g_idx;
   logic [GW-1:0]    size;
   logic [CW-1:0]    size_c;
   logic [CW-1:0]    g_c;
   logic [CW-1:0]    ng_c;
   logic [CW-1:0]    next_g_c;
   logic [CW-1:0]    need_sum;
   logic [CW+GS-1:0] alloc_off;
   logic             in_range;
   logic             fits;
   logic             can_split;
   logic [IW-1:0]    fg;
   logic             free_ok;

   ffba_ram #(
      .WIDTH (GW),
      .DEPTH (NUM_G)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign g_idx = g_ff[GW-1:0];
   // entry zero holds the whole arena until it is first written
   assign size      = (g_ff == '0 && !init_ff) ? GW'(NUM_G - 1) : mem_rdata;
   assign size_c    = CW'(size);
   assign g_c       = CW'(g_ff);
   assign in_range  = g_ff < (GW+1)'(NUM_G);
   assign fits      = size_c >= need_ff;
   assign can_split = size_c >= need_ff + CW'(2);
   assign ng_c      = g_c + CW'(1) + need_ff;
   assign next_g_c  = g_c + CW'(1) + size_c;
   assign alloc_off = {g_c + CW'(1), {GS{1'b0}}};
   assign need_sum  = CW'(req.request_bytes) + CW'(GRANULE_BYTES - 1);

   assign fg      = IW'(req.free_offset >> GS) - IW'(1);
   assign free_ok = (req.free_offset >= OFF_W'(GRANULE_BYTES))
                 && (req.free_offset[GS-1:0] == '0)
                 && (32'(fg) < 32'(NUM_G))
                 && start_ff[fg[GW-1:0]];

   assign req_ready = (state_ff == IDLE);
   assign res_valid = (state_ff == RESULT);
   assign res       = res_ff;

   always_comb begin
      state_in  = state_ff;
      start_in  = start_ff;
      used_in   = used_ff;
      init_in   = init_ff;
      g_in      = g_ff;
      need_in   = need_ff;
      ng_in     = ng_ff;
      rem_in    = rem_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = g_idx;
      mem_wdata = GW'(need_ff);
      mem_raddr = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               if (req.mode == MODE_ALLOC) begin
                  g_in     = '0;
                  need_in  = need_sum >> GS;
                  state_in = WALK;
               end else begin
                  res_in.payload_offset = '0;
                  if (free_ok) begin
                     used_in[fg[GW-1:0]] = 1'b0;
                     res_in.status       = STATUS_OK;
                  end else begin
                     res_in.status = STATUS_BAD_FREE;
                  end
                  state_in = RESULT;
               end
            end
         end
         WALK: begin
            if (!in_range || !start_ff[g_idx]) begin
               res_in.status         = STATUS_NO_SPACE;
               res_in.payload_offset = '0;
               state_in              = RESULT;
            end else if (!used_ff[g_idx] && fits) begin
               used_in[g_idx]        = 1'b1;
               res_in.status         = STATUS_OK;
               res_in.payload_offset = alloc_off[OFF_W-1:0];
               state_in              = RESULT;
               if (can_split && ng_c < CW'(NUM_G)) begin
                  // shrink this block now, write the remainder header next cycle
                  start_in[ng_c[GW-1:0]] = 1'b1;
                  used_in[ng_c[GW-1:0]]  = 1'b0;
                  mem_we                 = 1'b1;
                  if (g_idx == '0) begin
                     init_in = 1'b1;
                  end
                  ng_in    = ng_c[GW-1:0];
                  rem_in   = GW'(size_c - need_ff - CW'(1));
                  state_in = SPLIT;
               end
            end else begin
               g_in      = next_g_c[GW:0];
               mem_raddr = next_g_c[GW-1:0];
            end
         end
         SPLIT: begin
            mem_we    = 1'b1;
            mem_waddr = ng_ff;
            mem_wdata = rem_ff;
            state_in  = RESULT;
         end
         RESULT: begin
            if (res_ready) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      g_ff    <= g_in;
      need_ff <= need_in;
      ng_ff   <= ng_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      if (reset) begin
         state_ff <= IDLE;
         start_ff <= NUM_G'(1);
         used_ff  <= '0;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         used_ff  <= used_in;
         init_ff  <= init_in;
      end
   end

endmodule

@@ rtl/first_fit_block_allocator.sv @@
// Flow: a free goes from accept to RESULT and then to the output register
//   (rsp_tvalid); an allocate walks blocks in WALK until one is taken or the
//   list ends, and passes through SPLIT when the taken block is split.
// Throughput: one word at a time; walks one block per cycle via the size RAM.
// Reset: synchronous; the arena comes out as one free block, no RAM clearing.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a granule arena with block split and free by
// payload offset, behind stream request and response channels.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int ARENA_BYTES   = DEF_ARENA_BYTES,
   parameter int GRANULE_BYTES = DEF_GRANULE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // request_bytes, free_offset
   input  logic                  req_tuser,  // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // payload_offset
   output logic [STATUS_W-1:0]   rsp_tuser   // status
);

   req_type    req;
   logic       res_valid;
   logic       res_ready;
   result_type res;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff, rsp_res_in;

   assign req.mode          = req_tuser;
   assign req.request_bytes = req_tdata[REQ_W-1:0];
   assign req.free_offset   = req_tdata[REQ_W+OFF_W-1:REQ_W];

   ffba_engine #(
      .ARENA_BYTES   (ARENA_BYTES),
      .GRANULE_BYTES (GRANULE_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output word register holds one result so the engine can go on while the consumer stalls
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_res_ff.payload_offset);
   assign rsp_tuser  = rsp_res_ff.status;

`ifndef ASSERT_OFF
   a_handoff: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready |=> rsp_tvalid && rsp_tuser == $past(res.status))
      else $error("engine result not loaded into output register");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous word still in work");

   a_fail_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == '0)
      else $error("failed response carries a nonzero offset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_OK || rsp_tuser == STATUS_NO_SPACE
                      || rsp_tuser == STATUS_BAD_FREE))
      else $error("undefined status code");
`endif

endmodule
